>>> hw/rtl/kda_pkg.sv
`default_nettype none

package kda_pkg;

   localparam logic [7:0] HOLD_TOP  = 8'd205;
   localparam logic [7:0] HOLD_WRAP = 8'd200;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] REG_REPEAT_PERIOD      = 2'd0;
   localparam logic [1:0] REG_FAST_REPEAT_PERIOD = 2'd1;
   localparam logic [1:0] REG_ACCEL_THRESHOLD    = 2'd2;

   localparam logic [7:0] RST_REPEAT_PERIOD      = 8'd40;
   localparam logic [7:0] RST_FAST_REPEAT_PERIOD = 8'd20;
   localparam logic [7:0] RST_ACCEL_THRESHOLD    = 8'd40;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic div_step;
      logic div_end;
   } kda_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
   } kda_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/kda_dp.sv
`default_nettype none

module kda_dp import kda_pkg::*; #(
   parameter int FIFO_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire kda_cmd_type cmd,
   output kda_sts_type      sts,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_pins,
   input  wire logic [7:0]  repeat_period,
   input  wire logic [7:0]  fast_repeat_period,
   input  wire logic [7:0]  accel_threshold,
   output logic      [7:0]  rsp_key_code,
   output logic      [3:0]  rsp_queued
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CAPT,
      PH_HELD
   } phase_type;

   logic             op_ff, op_in;
   logic [7:0]       pins_ff, pins_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       hold_ff, hold_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       divisor_ff, divisor_in;
   logic [7:0]       dividend_ff, dividend_in;
   logic [7:0]       rem_ff, rem_in;
   logic [2:0]       step_ff, step_in;
   logic [7:0]       key_ff, key_in;
   logic [3:0]       queued_ff, queued_in;

   logic [7:0] mem [FIFO_DEPTH];

   logic       push;
   logic       pop;
   logic [7:0] push_code;
   logic       full;
   logic       empty;
   logic [7:0] hold_next;
   logic [7:0] period;
   logic [8:0] trial;
   logic       load_out;
   logic [7:0] out_code;

   assign full  = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign empty = (fill_ff == '0);

   // new hold count and the period that applies to it
   assign hold_next = (hold_ff < HOLD_TOP) ? hold_ff + 8'd1 : HOLD_WRAP;
   assign period    = (hold_next < accel_threshold) ? repeat_period : fast_repeat_period;
   assign trial     = {rem_ff, dividend_ff[7]};

   assign sts.need_div = (op_ff == OP_TICK) && (pins_ff != 8'd0) && (phase_ff == PH_HELD) &&
                         (held_ff == pins_ff);
   assign sts.div_last = (step_ff == 3'd7);

   always_comb begin
      op_in       = op_ff;
      pins_in     = pins_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      hold_in     = hold_ff;
      divisor_in  = divisor_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      key_in      = key_ff;
      queued_in   = queued_ff;
      push        = 1'b0;
      pop         = 1'b0;
      push_code   = held_ff;
      load_out    = 1'b0;
      out_code    = 8'd0;

      if (cmd.accept) begin
         op_in   = req_op;
         pins_in = req_pins;
      end

      if (cmd.exec) begin
         if (op_ff == OP_READ) begin
            load_out = 1'b1;
            if (!empty) begin
               pop      = 1'b1;
               out_code = rd_data_ff;
            end
         end else if (pins_ff == 8'd0) begin
            phase_in = PH_IDLE;
            load_out = 1'b1;
         end else begin
            load_out = 1'b1;
            case (phase_ff)
               PH_IDLE: begin
                  hold_in  = 8'd0;
                  held_in  = pins_ff;
                  phase_in = PH_CAPT;
               end
               PH_CAPT: begin
                  if (held_ff == pins_ff) begin
                     push      = 1'b1;
                     push_code = pins_ff;
                     phase_in  = PH_HELD;
                  end else begin
                     held_in = pins_ff;
                  end
               end
               PH_HELD: begin
                  if (held_ff == pins_ff) begin
                     // repeat check goes through the remainder unit
                     load_out    = 1'b0;
                     hold_in     = hold_next;
                     divisor_in  = period;
                     dividend_in = hold_next;
                     rem_in      = 8'd0;
                     step_in     = 3'd0;
                  end else begin
                     held_in  = pins_ff;
                     hold_in  = 8'd0;
                     phase_in = PH_CAPT;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // restoring remainder, one quotient bit a cycle
      if (cmd.div_step) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = 8'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[7:0];
         end
         dividend_in = {dividend_ff[6:0], 1'b0};
         step_in     = step_ff + 3'd1;
      end

      if (cmd.div_end) begin
         load_out = 1'b1;
         if ((divisor_ff != 8'd0) && (rem_ff == 8'd0)) begin
            push      = 1'b1;
            push_code = held_ff;
         end
      end

      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      if (push && !full) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff + CNT_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff - CNT_W'(1);
      end

      if (load_out) begin
         key_in    = out_code;
         queued_in = 4'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         held_ff   <= 8'd0;
         hold_ff   <= 8'd0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         hold_ff   <= hold_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pins_ff     <= pins_in;
      divisor_ff  <= divisor_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      key_ff      <= key_in;
      queued_ff   <= queued_in;
   end

   // key store
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem[wr_ptr_ff] <= push_code;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   assign rsp_key_code = key_ff;
   assign rsp_queued   = queued_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fill count beyond fifo depth");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("push and pop in one cycle");

   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      hold_ff <= HOLD_TOP)
      else $error("hold count beyond its top");

endmodule

`default_nettype wire

>>> hw/rtl/kda_ctrl.sv
`default_nettype none

module kda_ctrl import kda_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output kda_cmd_type      cmd,
   input  wire kda_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FIN,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in     = ST_EXEC;
               req_ready_in = 1'b0;
            end
         end
         ST_EXEC: begin
            if (sts.need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in     = ST_RESP;
               rsp_valid_in = 1'b1;
            end
         end
         ST_DIV: begin
            if (sts.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
            req_ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready    = req_ready_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.accept   = req_valid && req_ready_ff;
   assign cmd.exec     = (state_ff == ST_EXEC);
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.div_end  = (state_ff == ST_FIN);

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("new item taken while result pending");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sts.div_last) |=> (state_ff == ST_FIN))
      else $error("remainder unit overran its steps");

endmodule

`default_nettype wire

>>> hw/rtl/key_debounce_autorepeat_fifo_top.sv
// a read, or a tick that starts no repeat check, runs in EXEC and then holds its result in RESP
// a tick with the key still held runs the 8-step remainder unit: EXEC, DIV, FIN, then RESP
// one item at a time: a new item is taken only after the result of the last one is accepted
// the remainder unit works out one quotient bit a cycle
// reset is synchronous and active high: scanner idle, fifo empty, registers to 40, 20, 40
// key store contents are not cleared by reset
`default_nettype none

module key_debounce_autorepeat_fifo_top import kda_pkg::*; #(
   parameter int FIFO_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_pins,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_key_code,
   output logic      [3:0]  rsp_queued,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic [7:0]  repeat_period_ff;
   logic [7:0]  fast_repeat_period_ff;
   logic [7:0]  accel_threshold_ff;
   logic        csr_wr;
   kda_cmd_type cmd;
   kda_sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_period_ff      <= RST_REPEAT_PERIOD;
         fast_repeat_period_ff <= RST_FAST_REPEAT_PERIOD;
         accel_threshold_ff    <= RST_ACCEL_THRESHOLD;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_REPEAT_PERIOD:      repeat_period_ff      <= csr_pwdata[7:0];
            REG_FAST_REPEAT_PERIOD: fast_repeat_period_ff <= csr_pwdata[7:0];
            REG_ACCEL_THRESHOLD:    accel_threshold_ff    <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_REPEAT_PERIOD:      csr_prdata = {24'd0, repeat_period_ff};
         REG_FAST_REPEAT_PERIOD: csr_prdata = {24'd0, fast_repeat_period_ff};
         REG_ACCEL_THRESHOLD:    csr_prdata = {24'd0, accel_threshold_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   kda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   kda_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_op             (req_op),
      .req_pins           (req_pins),
      .repeat_period      (repeat_period_ff),
      .fast_repeat_period (fast_repeat_period_ff),
      .accel_threshold    (accel_threshold_ff),
      .rsp_key_code       (rsp_key_code),
      .rsp_queued         (rsp_queued)
   );

endmodule

`default_nettype wire

>>> bench/tb_key_debounce_autorepeat_fifo_top.sv
module tb_key_debounce_autorepeat_fifo_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kda_pkg::*;

   localparam int KEY_FIFO_DEPTH  = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_CAPTURED,
      SCAN_HELD
   } scan_phase_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic [3:0] queued;
   } key_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic        req_op      = OP_TICK;
   logic [7:0]  req_pins    = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [7:0]  rsp_key_code;
   logic [3:0]  rsp_queued;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = 4'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   key_debounce_autorepeat_fifo_top #(
      .FIFO_DEPTH(KEY_FIFO_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_pins     (req_pins),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_key_code (rsp_key_code),
      .rsp_queued   (rsp_queued),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scanner mirror
   logic [7:0]     cfg_repeat_period      = RST_REPEAT_PERIOD;
   logic [7:0]     cfg_fast_repeat_period = RST_FAST_REPEAT_PERIOD;
   logic [7:0]     cfg_accel_threshold    = RST_ACCEL_THRESHOLD;
   scan_phase_type scan_phase             = SCAN_IDLE;
   logic [7:0]     held_pins              = 8'd0;
   logic [7:0]     hold_ticks             = 8'd0;
   logic [7:0]     queued_codes[$];

   key_result_type pending_key_results[$];
   int unsigned key_items_sent  = 0;
   int unsigned mismatch_count  = 0;
   int unsigned stuck_cycles    = 0;
   int unsigned rx_stall_left   = 0;
   bit          rx_hold_req     = 1'b0;
   bit          rx_stalls_on    = 1'b1;
   bit          tx_gaps_on      = 1'b1;

   function automatic void push_key_code(input logic [7:0] code);
      // a full queue drops the code without a trace
      if (queued_codes.size() < KEY_FIFO_DEPTH)
         queued_codes.push_back(code);
   endfunction

   function automatic key_result_type predict_key_result(input logic op, input logic [7:0] pins);
      key_result_type res;
      logic [7:0]     period;
      res.key_code = 8'd0;
      if (op == OP_READ) begin
         if (queued_codes.size() != 0)
            res.key_code = queued_codes.pop_front();
      end else if (pins == 8'd0) begin
         scan_phase = SCAN_IDLE;
      end else begin
         case (scan_phase)
            SCAN_IDLE: begin
               hold_ticks = 8'd0;
               held_pins  = pins;
               scan_phase = SCAN_CAPTURED;
            end
            SCAN_CAPTURED: begin
               if (held_pins == pins) begin
                  push_key_code(pins);
                  scan_phase = SCAN_HELD;
               end else begin
                  held_pins = pins;
               end
            end
            SCAN_HELD: begin
               if (held_pins == pins) begin
                  hold_ticks = (hold_ticks < HOLD_TOP) ? 8'(hold_ticks + 8'd1) : HOLD_WRAP;
                  period = (hold_ticks < cfg_accel_threshold) ? cfg_repeat_period
                                                               : cfg_fast_repeat_period;
                  if (period != 8'd0 && (hold_ticks % period) == 8'd0)
                     push_key_code(held_pins);
               end else begin
                  held_pins  = pins;
                  hold_ticks = 8'd0;
                  scan_phase = SCAN_CAPTURED;
               end
            end
            default: scan_phase = SCAN_IDLE;
         endcase
      end
      res.queued = 4'(queued_codes.size());
      return res;
   endfunction

   function automatic logic [7:0] pick_key_pins();
      if ($urandom_range(0, 1) == 0)
         return 8'd1 << $urandom_range(0, 7);
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic send_key_item(input logic op, input logic [7:0] pins);
      int unsigned gap;
      gap = (tx_gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_pins  <= pins;
      do @(posedge clock); while (!req_ready);
      pending_key_results.push_back(predict_key_result(op, pins));
      key_items_sent++;
   endtask

   task automatic wait_key_idle();
      req_valid <= 1'b0;
      while (pending_key_results.size() != 0) @(posedge clock);
      // a held-key tick keeps the remainder unit busy for a while
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_reg(input logic [1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_REPEAT_PERIOD:      cfg_repeat_period      = value;
         REG_FAST_REPEAT_PERIOD: cfg_fast_repeat_period = value;
         REG_ACCEL_THRESHOLD:    cfg_accel_threshold    = value;
         default: ;
      endcase
   endtask

   task automatic set_key_timing(input logic [7:0] rep, input logic [7:0] fast,
                                 input logic [7:0] thr);
      wait_key_idle();
      write_key_reg(REG_REPEAT_PERIOD, rep);
      write_key_reg(REG_FAST_REPEAT_PERIOD, fast);
      write_key_reg(REG_ACCEL_THRESHOLD, thr);
   endtask

   // press, optional bounce, hold with reads mixed in, mostly a release at the end
   task automatic play_key_press(input bit long_hold);
      logic [7:0]  pins;
      int unsigned hold_len;
      int unsigned read_odds;
      pins      = pick_key_pins();
      hold_len  = long_hold ? $urandom_range(206, 240) : $urandom_range(0, 30);
      read_odds = long_hold ? 3 : $urandom_range(2, 6);
      send_key_item(OP_TICK, pins);
      if ($urandom_range(0, 5) == 0) begin
         pins = pick_key_pins();
         send_key_item(OP_TICK, pins);
      end
      send_key_item(OP_TICK, pins);
      repeat (hold_len) begin
         while ($urandom_range(1, read_odds) == 1)
            send_key_item(OP_READ, 8'($urandom));
         if ($urandom_range(0, 40) == 0) begin
            pins = pick_key_pins();
            send_key_item(OP_TICK, pins);
         end
         send_key_item(OP_TICK, pins);
      end
      if ($urandom_range(0, 4) != 0)
         send_key_item(OP_TICK, 8'd0);
      repeat ($urandom_range(0, 4))
         send_key_item(OP_READ, 8'($urandom));
   endtask

   task automatic run_key_phase(input int unsigned n_items, input bit long_first);
      int unsigned stop_at;
      stop_at = key_items_sent + n_items;
      if (long_first)
         play_key_press(1'b1);
      while (key_items_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6))
               send_key_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            play_key_press(1'b0);
         end
      end
   endtask

   task automatic test_scan_sequences();
      set_key_timing(RST_REPEAT_PERIOD, RST_FAST_REPEAT_PERIOD, RST_ACCEL_THRESHOLD);
      send_key_item(OP_READ, 8'hFF);
      send_key_item(OP_TICK, 8'h00);
      send_key_item(OP_TICK, 8'hFF);
      // changed snapshot while captured
      send_key_item(OP_TICK, 8'h01);
      send_key_item(OP_TICK, 8'h01);
      // changed snapshot while held
      send_key_item(OP_TICK, 8'h80);
      send_key_item(OP_TICK, 8'h80);
      send_key_item(OP_TICK, 8'h00);
      send_key_item(OP_READ, 8'h00);
      send_key_item(OP_READ, 8'hFF);
      send_key_item(OP_READ, 8'h00);
   endtask

   task automatic test_zero_period();
      set_key_timing(8'd0, 8'd0, 8'd0);
      repeat (5) send_key_item(OP_TICK, 8'h55);
      send_key_item(OP_TICK, 8'h00);
      send_key_item(OP_READ, 8'h00);
   endtask

   task automatic test_full_fifo();
      set_key_timing(8'd1, 8'd1, 8'hFF);
      // one code per held tick, so the queue overflows
      repeat (10) send_key_item(OP_TICK, 8'hAA);
      send_key_item(OP_TICK, 8'h00);
      send_key_item(OP_READ, 8'hAA);
   endtask

   task automatic test_output_backpressure();
      set_key_timing(8'd1, 8'd1, 8'd0);
      rx_hold_req = 1'b1;
      repeat (3) play_key_press(1'b0);
   endtask

   task automatic test_random_settings();
      logic [7:0] rep_list[8]  = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd40, 8'd2, 8'd5, 8'd13};
      logic [7:0] fast_list[8] = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd20, 8'd1, 8'd3, 8'd255};
      logic [7:0] thr_list[8]  = '{8'd0, 8'd255, 8'd20, 8'd30, 8'd40, 8'd5, 8'd100, 8'd200};
      for (int i = 0; i < 9; i++) begin
         if (i == 8)
            set_key_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                           8'($urandom));
         else
            set_key_timing(rep_list[i], fast_list[i], thr_list[i]);
         run_key_phase(70, i == 0 || i == 5);
      end
   endtask

   task automatic test_quiet_finish();
      wait_key_idle();
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      set_key_timing(8'd3, 8'd2, 8'd12);
      run_key_phase(120, 1'b0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_scan_sequences();
      test_zero_period();
      test_full_fifo();
      test_output_backpressure();
      test_random_settings();
      test_quiet_finish();
      wait_key_idle();
      if (mismatch_count == 0)
         $display("tb_key_debounce_autorepeat_fifo_top passed");
      else
         $display("tb_key_debounce_autorepeat_fifo_top failed");
      $finish;
   end

   // result side: random stall bursts, one long hold-off on request
   always @(posedge clock) begin
      if (rx_hold_req) begin
         rx_hold_req   = 1'b0;
         rx_stall_left = HOLD_OFF_CYCLES;
      end else if (rx_stall_left == 0 && rx_stalls_on && $urandom_range(0, 7) == 0) begin
         rx_stall_left = $urandom_range(1, 13);
      end
      if (rx_stall_left != 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_key_results.size() == 0) begin
            $error("unexpected result transfer: key_code %0d queued %0d",
                   rsp_key_code, rsp_queued);
            mismatch_count++;
         end else begin
            want = pending_key_results.pop_front();
            if (rsp_key_code !== want.key_code) begin
               $error("key_code: expected %0d, got %0d", want.key_code, rsp_key_code);
               mismatch_count++;
            end
            if (rsp_queued !== want.queued) begin
               $error("queued: expected %0d, got %0d", want.queued, rsp_queued);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_key_debounce_autorepeat_fifo_top failed");
         $finish;
      end
   end

endmodule
